// File: src/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ASSERT_PROP checks an implication or sequence property on every clock edge.
// ASSERT_NEVER flags a condition that must not be true on any clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: src/esd_pkg.sv
`timescale 1ns / 1ps

package esd_pkg;

    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] END_BYTE   = 8'h1A;
    localparam logic [1:0] TRAILER_LEN = 2'd3;

    // Window sizes: start escape is eight bytes, end escape five.
    localparam int HIST_DEPTH = 8;
    localparam int END_LEN    = 5;
    localparam int LOOKAHEAD  = 5;
    // The newest byte is taken straight from the input, so the chain
    // stores one byte fewer than the start window.
    localparam int CHAIN_LEN  = HIST_DEPTH - 1;

    typedef enum logic [2:0] {
        MODE_HUNT    = 3'b001,
        MODE_PAYLOAD = 3'b010,
        MODE_TRAILER = 3'b100
    } esd_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
    } esd_tap_t;

    // Start escape, newest byte at position 0.
    function automatic logic [7:0] start_pat_byte(input int pos);
        logic [7:0] b;
        case (pos)
            0, 1, 2, 3: b = START_BYTE;
            default:    b = ESC_BYTE;
        endcase
        return b;
    endfunction

    // End escape, newest byte at position 0; positions past it never match.
    function automatic logic [7:0] end_pat_byte(input int pos);
        logic [7:0] b;
        case (pos)
            0:          b = END_BYTE;
            1, 2, 3, 4: b = ESC_BYTE;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: src/esd_cell.sv
`timescale 1ns / 1ps

module esd_cell
    import esd_pkg::*;
#(
    parameter int POS = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     shift_en,
    input  logic     clear,
    input  esd_tap_t tap_in,
    output esd_tap_t tap_out,
    output logic     hit_start,
    output logic     hit_end
);

    // After the next shift this byte sits one place further back.
    localparam int HIST_IDX = POS + 1;
    localparam logic [7:0] START_REF = start_pat_byte(HIST_IDX);
    localparam logic [7:0] END_REF   = end_pat_byte(HIST_IDX);
    localparam logic       IN_END    = (HIST_IDX < END_LEN);

    logic [7:0] data_reg;
    logic       valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= tap_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= tap_in.data;
        end
    end

    assign tap_out.data  = data_reg;
    assign tap_out.valid = valid_reg;
    assign hit_start     = (data_reg == START_REF);
    assign hit_end       = IN_END && (data_reg == END_REF);

endmodule

// File: src/escape_sequence_deframer_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Escape-sequence deframer. Feed one received byte per transaction on the
// slave stream; the master stream carries the payload bytes of each frame
// and, after the trailer, one frame-end transaction (tlast high, tdata zero).
// While hunting, the block watches the last eight bytes for the start escape
// 1B 1B 1B 1B 01 01 01 01. Inside a frame, payload is released five bytes
// late so that the end escape 1B 1B 1B 1B 1A is recognized and stripped; the
// three trailer bytes that follow (fill count and CRC) are dropped without a
// check, then the frame-end transaction is sent and hunting resumes. An empty
// frame gives only the frame-end transaction. Doubled escapes inside the
// payload are passed on unchanged, and no start escape is looked for inside
// a frame. Rate: one byte per clock cycle, sustained while m_tready is high;
// the result of a transaction is loaded into the output register on
// acceptance, and a payload byte is only released once five more bytes have
// come in. The history is a chain of seven byte cells, each comparing its
// byte against both escape patterns, so the whole window is matched in the
// cycle the new byte arrives. The output register accepts a new byte
// whenever it is empty or is being drained.
module escape_sequence_deframer_unit
    import esd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // frame_end
);

    esd_mode_t  mode_reg, mode_next;
    logic [1:0] trailer_left_reg, trailer_left_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;
    logic       out_last_reg, out_last_next;

    logic       accept;
    logic       in_hunt, in_payload, in_trailer;
    logic       shift_en, clear;
    logic       start_hit, end_hit, trailer_done;
    logic       res_valid;
    logic [7:0] res_data;
    logic       res_last;

    esd_tap_t             chain_in  [0:CHAIN_LEN-1];
    esd_tap_t             taps      [0:CHAIN_LEN-1];
    logic [CHAIN_LEN-1:0] hit_start;
    logic [CHAIN_LEN-1:0] hit_end;

    // Take a byte whenever the output register is free or drains this cycle.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign in_hunt    = (mode_reg == MODE_HUNT);
    assign in_payload = (mode_reg == MODE_PAYLOAD);
    assign in_trailer = (mode_reg == MODE_TRAILER);

    // History chain: cell 0 takes the new byte, each cell hands on to the next.
    genvar gi;
    generate
        for (gi = 0; gi < CHAIN_LEN; gi++)
        begin : g_chain
            if (gi == 0)
            begin : g_head
                assign chain_in[gi].data  = s_tdata;
                assign chain_in[gi].valid = 1'b1;
            end
            else
            begin : g_link
                assign chain_in[gi] = taps[gi-1];
            end

            esd_cell #(
                .POS (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (shift_en),
                .clear     (clear),
                .tap_in    (chain_in[gi]),
                .tap_out   (taps[gi]),
                .hit_start (hit_start[gi]),
                .hit_end   (hit_end[gi])
            );
        end
    endgenerate

    // Match against the window as it stands once the new byte is shifted in:
    // the incoming byte is the newest entry, cell k holds entry k+1.
    assign start_hit = (s_tdata == start_pat_byte(0)) && (&hit_start)
                       && taps[CHAIN_LEN-1].valid;
    assign end_hit   = (s_tdata == end_pat_byte(0)) && (&hit_end[END_LEN-2:0])
                       && taps[END_LEN-2].valid;
    assign trailer_done = (trailer_left_reg <= 2'd1);

    // The trailer leaves the history untouched; only hunt and payload shift.
    assign shift_en = accept && (in_hunt || in_payload);
    assign clear    = accept && ((in_hunt && start_hit) || (in_payload && end_hit)
                                 || (in_trailer && trailer_done));

    // Result of this transaction: a delayed payload byte or the frame-end marker.
    always_comb
    begin
        res_valid = 1'b0;
        res_data  = 8'h00;
        res_last  = 1'b0;
        if (accept && in_payload && taps[LOOKAHEAD-1].valid)
        begin
            res_valid = 1'b1;
            res_data  = taps[LOOKAHEAD-1].data;
        end
        else if (accept && in_trailer && trailer_done)
        begin
            res_valid = 1'b1;
            res_last  = 1'b1;
        end
    end

    // Mode sequencing.
    always_comb
    begin
        mode_next         = mode_reg;
        trailer_left_next = trailer_left_reg;
        if (accept)
        begin
            case (mode_reg)
                MODE_HUNT:
                begin
                    if (start_hit)
                    begin
                        mode_next = MODE_PAYLOAD;
                    end
                end
                MODE_PAYLOAD:
                begin
                    if (end_hit)
                    begin
                        mode_next         = MODE_TRAILER;
                        trailer_left_next = TRAILER_LEN;
                    end
                end
                MODE_TRAILER:
                begin
                    if (trailer_done)
                    begin
                        mode_next         = MODE_HUNT;
                        trailer_left_next = 2'd0;
                    end
                    else
                    begin
                        trailer_left_next = trailer_left_reg - 2'd1;
                    end
                end
                default:
                begin
                    mode_next = MODE_HUNT;
                end
            endcase
        end
    end

    // Output register: load a new result, otherwise hold until drained.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_data;
            out_last_next  = res_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_HUNT;
            trailer_left_reg <= 2'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            mode_reg         <= mode_next;
            trailer_left_reg <= trailer_left_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // A frame-end marker never carries data.
    `ASSERT_PROP(a_marker_zero, clk, rst_n, (m_tvalid && m_tlast) |-> (m_tdata == 8'h00))
    // In the trailer there is always at least one byte left to drop.
    `ASSERT_NEVER(a_trailer_count, clk, rst_n, in_trailer && (trailer_left_reg == 2'd0))
    // A new output only appears after an input transaction.
    `ASSERT_PROP(a_out_cause, clk, rst_n, $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    // Entering a frame happens only on a full start-escape window.
    `ASSERT_PROP(a_enter_frame, clk, rst_n, (in_hunt && accept && !start_hit) |=> !in_payload)

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import esd_pkg::*;

    localparam int ITEM_TARGET = 1300;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_PCT = 31;
    localparam int DIRECTED_ROWS = 26;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_out_t;

    // One row of the directed part; fixed rows carry their own result.
    typedef struct packed {
        logic [7:0] rx;
        logic       fixed;
        logic [7:0] fix_byte;
        logic       fix_last;
    } stim_row_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // Side information travelling with the byte on s_tdata.
    logic       row_fixed = 1'b0;
    logic [7:0] row_fix_byte = 8'h00;
    logic       row_fix_last = 1'b0;

    logic       steady = 1'b0;
    int         err_count = 0;
    int         cycle_count = 0;
    int         item_count = 0;

    frame_out_t pending_out [$];
    stim_row_t  stim_rows [DIRECTED_ROWS];

    // Predictor state
    esd_mode_t  rx_mode = MODE_HUNT;
    logic [7:0] rx_hist [HIST_DEPTH];
    int         rx_fill = 0;
    logic [1:0] trailer_cnt = 2'd0;

    escape_sequence_deframer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic clear_history();
        int i;
        for (i = 0; i < HIST_DEPTH; i++)
            rx_hist[i] = 8'h00;
        rx_fill = 0;
    endtask

    task automatic shift_history(input logic [7:0] b);
        int i;
        for (i = HIST_DEPTH - 1; i > 0; i--)
            rx_hist[i] = rx_hist[i - 1];
        rx_hist[0] = b;
    endtask

    // Append one expected output transaction at the tail of the queue.
    task automatic queue_result(input frame_out_t item);
        pending_out.insert(pending_out.size(), item);
    endtask

    // Advance the deframer state by one received byte; report the result, if any.
    task automatic deframe_byte(input logic [7:0] b, output logic has,
                                output logic [7:0] ob, output logic fe);
        int   i;
        int   n;
        logic hit;
        has = 1'b0;
        ob  = 8'h00;
        fe  = 1'b0;
        case (rx_mode)
            MODE_PAYLOAD:
            begin
                shift_history(b);
                n = rx_fill + 1;
                if (n > LOOKAHEAD + 1)
                    n = LOOKAHEAD + 1;
                // release the byte that has fallen out of the look-ahead window
                if (n > LOOKAHEAD)
                begin
                    has = 1'b1;
                    ob  = rx_hist[LOOKAHEAD];
                end
                hit = (rx_hist[0] == END_BYTE);
                for (i = 1; i < END_LEN; i++)
                    hit = hit && (rx_hist[i] == ESC_BYTE);
                if (n >= LOOKAHEAD && hit)
                begin
                    rx_mode     = MODE_TRAILER;
                    trailer_cnt = TRAILER_LEN;
                    clear_history();
                end
                else
                begin
                    rx_fill = (n > LOOKAHEAD) ? LOOKAHEAD : n;
                end
            end
            MODE_TRAILER:
            begin
                if (trailer_cnt <= 2'd1)
                begin
                    trailer_cnt = 2'd0;
                    rx_mode     = MODE_HUNT;
                    clear_history();
                    has = 1'b1;
                    fe  = 1'b1;
                end
                else
                begin
                    trailer_cnt = trailer_cnt - 2'd1;
                end
            end
            default:
            begin
                rx_mode = MODE_HUNT;
                shift_history(b);
                if (rx_fill < HIST_DEPTH)
                    rx_fill++;
                hit = 1'b1;
                for (i = 0; i < HIST_DEPTH; i++)
                    hit = hit && (rx_hist[i] == ((i < 4) ? START_BYTE : ESC_BYTE));
                if (rx_fill >= HIST_DEPTH && hit)
                begin
                    rx_mode = MODE_PAYLOAD;
                    clear_history();
                end
            end
        endcase
    endtask

    // Check the output transaction first, then predict the accepted input.
    always @(posedge clk)
    begin : monitor
        frame_out_t want;
        logic       has;
        logic [7:0] ob;
        logic       fe;
        cycle_count++;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_out.size() == 0)
                begin
                    $display("%0t ns: unexpected output: expected none, actual %02h last %0b",
                             $time, m_tdata, m_tlast);
                    err_count++;
                end
                else
                begin
                    want = pending_out.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        $display("%0t ns: out_byte mismatch: expected %02h, actual %02h",
                                 $time, want.data, m_tdata);
                        err_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t ns: frame_end mismatch: expected %0b, actual %0b",
                                 $time, want.last, m_tlast);
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                deframe_byte(s_tdata, has, ob, fe);
                if (row_fixed)
                    queue_result(frame_out_t'{row_fix_byte, row_fix_last});
                else if (has)
                    queue_result(frame_out_t'{ob, fe});
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: stall at random except during the steady stretch.
    always @(negedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Enter at a falling edge; exactly one update of s_tvalid per edge.
    task automatic drive_byte(input logic [7:0] b, input logic fixed = 1'b0,
                              input logic [7:0] fb = 8'h00, input logic fl = 1'b0);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid     <= 1'b1;
        s_tdata      <= b;
        row_fixed    <= fixed;
        row_fix_byte <= fb;
        row_fix_last <= fl;
        do
            @(posedge clk);
        while (!s_tready);
        item_count++;
        steady <= (item_count >= 500 && item_count < 750);
        @(negedge clk);
    endtask

    // Drop valid and hold until every pending result has been drained.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_out.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_start_prefix(input int count);
        int i;
        for (i = 0; i < count; i++)
            drive_byte((i < 4) ? ESC_BYTE : START_BYTE);
    endtask

    task automatic send_end_escape();
        repeat (4) drive_byte(ESC_BYTE);
        drive_byte(END_BYTE);
    endtask

    // Bias toward escape-related codes so partial matches show up often.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return ESC_BYTE;
        else if (r < 35)
            return START_BYTE;
        else if (r < 42)
            return END_BYTE;
        else if (r < 47)
            return 8'h00;
        else if (r < 52)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    initial
    begin : stimulus
        int         frame_no;
        int         slots;
        int         r;
        int         k;
        logic [7:0] b;

        clear_history();
        stim_rows = '{
            // empty frame: start escape straight into end escape
            '{ESC_BYTE,   1'b0, 8'h00, 1'b0}, '{ESC_BYTE,   1'b0, 8'h00, 1'b0},
            '{ESC_BYTE,   1'b0, 8'h00, 1'b0}, '{ESC_BYTE,   1'b0, 8'h00, 1'b0},
            '{START_BYTE, 1'b0, 8'h00, 1'b0}, '{START_BYTE, 1'b0, 8'h00, 1'b0},
            '{START_BYTE, 1'b0, 8'h00, 1'b0}, '{START_BYTE, 1'b0, 8'h00, 1'b0},
            '{ESC_BYTE,   1'b0, 8'h00, 1'b0}, '{ESC_BYTE,   1'b0, 8'h00, 1'b0},
            '{ESC_BYTE,   1'b0, 8'h00, 1'b0}, '{ESC_BYTE,   1'b0, 8'h00, 1'b0},
            '{END_BYTE,   1'b0, 8'h00, 1'b0},
            // trailer; the last byte yields only the frame-end marker
            '{8'hA5,      1'b0, 8'h00, 1'b0}, '{8'h5A,      1'b0, 8'h00, 1'b0},
            '{8'h3C,      1'b1, 8'h00, 1'b1},
            // open a frame and feed the byte extremes into the look-ahead
            '{ESC_BYTE,   1'b0, 8'h00, 1'b0}, '{ESC_BYTE,   1'b0, 8'h00, 1'b0},
            '{ESC_BYTE,   1'b0, 8'h00, 1'b0}, '{ESC_BYTE,   1'b0, 8'h00, 1'b0},
            '{START_BYTE, 1'b0, 8'h00, 1'b0}, '{START_BYTE, 1'b0, 8'h00, 1'b0},
            '{START_BYTE, 1'b0, 8'h00, 1'b0}, '{START_BYTE, 1'b0, 8'h00, 1'b0},
            '{8'hFF,      1'b0, 8'h00, 1'b0}, '{8'h00,      1'b0, 8'h00, 1'b0}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (k = 0; k < DIRECTED_ROWS; k++)
            drive_byte(stim_rows[k].rx, stim_rows[k].fixed,
                       stim_rows[k].fix_byte, stim_rows[k].fix_last);
        hold_until_drained();

        frame_no = 0;
        while (item_count < ITEM_TARGET)
        begin
            frame_no++;
            // line noise between frames
            repeat ($urandom_range(0, 3)) drive_byte(pick_byte());
            r = $urandom_range(99);
            if (r < 10)
            begin
                // truncated start escape followed by junk
                send_start_prefix($urandom_range(1, 7));
                drive_byte(8'($urandom));
            end
            else
            begin
                send_start_prefix(8);
                slots = ($urandom_range(99) < 90) ? $urandom_range(0, 8)
                                                   : $urandom_range(9, 40);
                repeat (slots)
                begin
                    k = $urandom_range(99);
                    if (k < 8)
                        repeat (8) drive_byte(ESC_BYTE);    // doubled escape
                    else if (k < 12)
                        send_start_prefix(8);               // start escape in payload
                    else if (k < 18)
                    begin
                        // almost an end escape
                        repeat (4) drive_byte(ESC_BYTE);
                        b = pick_byte();
                        drive_byte((b == END_BYTE) ? 8'h00 : b);
                    end
                    else
                        drive_byte(pick_byte());
                end
                if (r < 90)
                begin
                    send_end_escape();
                    repeat (3) drive_byte(8'($urandom));
                end
                else
                begin
                    // broken end escape; the frame stays open
                    repeat ($urandom_range(1, 3)) drive_byte(ESC_BYTE);
                    drive_byte(8'($urandom));
                end
            end
            if (frame_no % 40 == 20)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
